FILE: hdl/cvea_pkg.sv
// ----------------------------------------------------------------------------
// cvea_pkg
// Shared widths, codes and item records of the calorimeter vector Et
// accumulator.
// ----------------------------------------------------------------------------
package cvea_pkg;

  // Fixed-point configuration
  localparam int PHI_BITS      = 12;
  localparam int ETA_FRAC_BITS = 8;
  localparam int ACC_BITS      = 40;

  // Field widths
  localparam int NUM_REGIONS = 4;
  localparam int REGION_W    = 2;
  localparam int ETA_W       = 12;
  localparam int PHI_W       = 12;
  localparam int ENERGY_W    = 17;
  localparam int SUM_W       = 40;

  // Arithmetic widths
  localparam int Q16_W     = 17;                        // unsigned Q1.16, up to 1.0
  localparam int TRIG_W    = Q16_W + 1;                 // signed sin / cos
  localparam int P_W       = ENERGY_W + Q16_W + 1;      // energy * sech
  localparam int PC_W      = P_W + TRIG_W;              // p * cos, p * sin
  localparam int ET_SHIFT  = 16;
  localparam int EX_SHIFT  = 32;
  localparam int TERM_W    = PC_W - EX_SHIFT;           // rounded terms
  localparam int SIN_IDX_W = PHI_BITS - 1;              // 0 .. quarter inclusive

  // Stream widths
  localparam int S_TDATA_W = ((REGION_W + ETA_W + PHI_W + ENERGY_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((REGION_W + 4 * SUM_W + 7) / 8) * 8;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  // Table lookups, one per item
  typedef struct packed {
    logic [Q16_W-1:0] sech;
    logic [Q16_W-1:0] sin_mag;
    logic [Q16_W-1:0] cos_mag;
    logic             sin_neg;
    logic             cos_neg;
  } trig_t;

  // Rounded terms of one item, ready for accumulation
  typedef struct packed {
    logic                      cmd;
    logic [REGION_W-1:0]       region;
    logic signed [TERM_W-1:0]  ex;
    logic signed [TERM_W-1:0]  ey;
    logic signed [TERM_W-1:0]  energy;
    logic signed [TERM_W-1:0]  et;
  } term_t;

  // One region's accumulator record
  typedef struct packed {
    logic                       sat;
    logic signed [ACC_BITS-1:0] trans;
    logic signed [ACC_BITS-1:0] energy;
    logic signed [ACC_BITS-1:0] ey;
    logic signed [ACC_BITS-1:0] ex;
  } acc_rec_t;

  // Read-out requests from the close sequencer
  typedef struct packed {
    logic                rd_en;
    logic                clr;
    logic [REGION_W-1:0] idx;
  } drain_t;

endpackage

FILE: hdl/cvea_trig_rom.sv
// ----------------------------------------------------------------------------
// cvea_trig_rom
// Registered lookups of sech(eta) and of sin / cos(phi) in Q1.16, with the
// full circle folded onto a quarter-wave table.
// ----------------------------------------------------------------------------
module cvea_trig_rom (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic signed [cvea_pkg::ETA_W-1:0]   eta_i,
  input  logic        [cvea_pkg::PHI_W-1:0]   phi_i,
  output cvea_pkg::trig_t                     trig_o
);

  localparam int PHI_BITS   = cvea_pkg::PHI_BITS;
  localparam int Q16_W      = cvea_pkg::Q16_W;
  localparam int SIN_IDX_W  = cvea_pkg::SIN_IDX_W;
  localparam int ETA_W      = cvea_pkg::ETA_W;
  localparam int EFB        = cvea_pkg::ETA_FRAC_BITS;
  localparam int QUARTER    = 2 ** (PHI_BITS - 2);
  localparam int SIN_DEPTH  = QUARTER + 1;
  localparam int SECH_DEPTH = 2 ** (ETA_W - 1) + 1;
  localparam int SECH_INT_MAX = 2 ** (ETA_W - 1 - EFB);

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] EXP_M1_Q30  = 64'd395007542;
  localparam logic [63:0] FRAC_MASK   = (64'd1 << EFB) - 64'd1;

  typedef logic [Q16_W-1:0] q16_t;
  typedef q16_t sin_lut_t [SIN_DEPTH];
  typedef q16_t sech_lut_t [SECH_DEPTH];

  typedef struct packed {
    logic                 neg;
    logic [SIN_IDX_W-1:0] idx;
  } fold_t;

  // sin of m quarter-steps, Taylor series to x^15 in Q30
  function automatic q16_t quarter_sin(input logic [63:0] m);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (m * HALF_PI_Q30) >> (PHI_BITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; acc = acc - $signed(term);
    if (acc < 0) acc = '0;
    return Q16_W'(($unsigned(acc) + 64'd8192) >> 14);
  endfunction

  // sech = 2E / (1 + E^2), E = exp(-|eta|)
  function automatic q16_t sech_q16(input logic [63:0] mag);
    logic [63:0]        n;
    logic [63:0]        f;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        e2;
    logic [63:0]        den;
    logic [63:0]        num;
    logic [63:0]        quo;
    logic [63:0]        rem;
    logic signed [63:0] acc;
    n    = mag >> EFB;
    f    = (mag & FRAC_MASK) << (30 - EFB);
    term = Q30_ONE;
    acc  = $signed(Q30_ONE);
    term = (term * f) >> 30;               acc = acc - $signed(term);
    term = ((term * f) >> 30) / 64'd2;     acc = acc + $signed(term);
    term = ((term * f) >> 30) / 64'd3;     acc = acc - $signed(term);
    term = ((term * f) >> 30) / 64'd4;     acc = acc + $signed(term);
    term = ((term * f) >> 30) / 64'd5;     acc = acc - $signed(term);
    term = ((term * f) >> 30) / 64'd6;     acc = acc + $signed(term);
    term = ((term * f) >> 30) / 64'd7;     acc = acc - $signed(term);
    term = ((term * f) >> 30) / 64'd8;     acc = acc + $signed(term);
    term = ((term * f) >> 30) / 64'd9;     acc = acc - $signed(term);
    term = ((term * f) >> 30) / 64'd10;    acc = acc + $signed(term);
    term = ((term * f) >> 30) / 64'd11;    acc = acc - $signed(term);
    term = ((term * f) >> 30) / 64'd12;    acc = acc + $signed(term);
    if (acc < 0) acc = '0;
    e = $unsigned(acc);
    for (int i = 0; i < SECH_INT_MAX; i++) begin
      if (64'(i) < n) e = (e * EXP_M1_Q30) >> 30;
    end
    e2  = (e * e) >> 30;
    den = Q30_ONE + e2;
    num = e << 31;
    quo = '0;
    rem = '0;
    // long division, evaluated at elaboration only
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return Q16_W'((quo + 64'd8192) >> 14);
  endfunction

  function automatic sin_lut_t gen_sin_lut();
    sin_lut_t lut;
    for (int m = 0; m < SIN_DEPTH; m++) lut[m] = quarter_sin(64'(m));
    return lut;
  endfunction

  function automatic sech_lut_t gen_sech_lut();
    sech_lut_t lut;
    for (int m = 0; m < SECH_DEPTH; m++) lut[m] = sech_q16(64'(m));
    return lut;
  endfunction

  localparam sin_lut_t  SIN_ROM  = gen_sin_lut();
  localparam sech_lut_t SECH_ROM = gen_sech_lut();

  function automatic fold_t fold(input logic [PHI_BITS-1:0] a);
    fold_t res;
    res.neg = a[PHI_BITS-1];
    res.idx = a[PHI_BITS-2] ? SIN_IDX_W'(QUARTER) - SIN_IDX_W'(a[PHI_BITS-3:0])
                            : SIN_IDX_W'(a[PHI_BITS-3:0]);
    return res;
  endfunction

  logic [PHI_BITS-1:0] phi_w;
  logic [ETA_W-1:0]    eta_mag;
  fold_t               sin_f;
  fold_t               cos_f;

  always_comb begin
    phi_w   = PHI_BITS'(phi_i);
    // -2048 folds onto 2048, still within the table
    eta_mag = eta_i[ETA_W-1] ? ETA_W'(-eta_i) : ETA_W'(eta_i);
    sin_f   = fold(phi_w);
    cos_f   = fold(phi_w + PHI_BITS'(QUARTER));
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      trig_o.sech    <= SECH_ROM[eta_mag];
      trig_o.sin_mag <= SIN_ROM[sin_f.idx];
      trig_o.cos_mag <= SIN_ROM[cos_f.idx];
      trig_o.sin_neg <= sin_f.neg;
      trig_o.cos_neg <= cos_f.neg;
    end
  end

endmodule

FILE: hdl/cvea_et_pipe.sv
// ----------------------------------------------------------------------------
// cvea_et_pipe
// Product pipeline: p = energy * sech, then p * cos and p * sin with et
// rounded from p, then rounding of the cos and sin terms to whole counts.
// ----------------------------------------------------------------------------
module cvea_et_pipe (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic                                  cmd_i,
  input  logic        [cvea_pkg::REGION_W-1:0]  region_i,
  input  logic signed [cvea_pkg::ENERGY_W-1:0]  energy_i,
  input  cvea_pkg::trig_t                       trig_i,
  output logic                                  term_valid_o,
  output cvea_pkg::term_t                       term_o
);

  localparam int P_W      = cvea_pkg::P_W;
  localparam int PC_W     = cvea_pkg::PC_W;
  localparam int TRIG_W   = cvea_pkg::TRIG_W;
  localparam int TERM_W   = cvea_pkg::TERM_W;
  localparam int REGION_W = cvea_pkg::REGION_W;
  localparam int ENERGY_W = cvea_pkg::ENERGY_W;

  localparam logic signed [P_W-1:0]  RND_P  = P_W'(1) << (cvea_pkg::ET_SHIFT - 1);
  localparam logic signed [PC_W-1:0] RND_PC = PC_W'(1) << (cvea_pkg::EX_SHIFT - 1);

  // stage 1: sideband alongside the table read
  logic                       v1_q;
  logic                       cmd1_q;
  logic [REGION_W-1:0]        region1_q;
  logic signed [ENERGY_W-1:0] en1_q;

  // stage 2: p and signed trig values
  logic                       v2_q;
  logic                       cmd2_q;
  logic [REGION_W-1:0]        region2_q;
  logic signed [ENERGY_W-1:0] en2_q;
  logic signed [P_W-1:0]      p2_d, p2_q;
  logic signed [TRIG_W-1:0]   sin2_d, sin2_q;
  logic signed [TRIG_W-1:0]   cos2_d, cos2_q;

  // stage 3: products and et
  logic                       v3_q;
  logic                       cmd3_q;
  logic [REGION_W-1:0]        region3_q;
  logic signed [ENERGY_W-1:0] en3_q;
  logic signed [PC_W-1:0]     pc3_d, pc3_q;
  logic signed [PC_W-1:0]     ps3_d, ps3_q;
  logic signed [TERM_W-1:0]   et3_d, et3_q;

  // stage 4: rounded terms
  logic                       v4_q;
  cvea_pkg::term_t            term4_d, term4_q;

  logic signed [TRIG_W-1:0]   sin_abs;
  logic signed [TRIG_W-1:0]   cos_abs;

  always_comb begin
    sin_abs = $signed({1'b0, trig_i.sin_mag});
    cos_abs = $signed({1'b0, trig_i.cos_mag});
    p2_d    = P_W'(en1_q) * P_W'($signed({1'b0, trig_i.sech}));
    sin2_d  = trig_i.sin_neg ? -sin_abs : sin_abs;
    cos2_d  = trig_i.cos_neg ? -cos_abs : cos_abs;

    pc3_d   = PC_W'(p2_q) * PC_W'(cos2_q);
    ps3_d   = PC_W'(p2_q) * PC_W'(sin2_q);
    et3_d   = TERM_W'((p2_q + RND_P) >>> cvea_pkg::ET_SHIFT);

    term4_d.cmd    = cmd3_q;
    term4_d.region = region3_q;
    term4_d.ex     = TERM_W'((pc3_q + RND_PC) >>> cvea_pkg::EX_SHIFT);
    term4_d.ey     = TERM_W'((ps3_q + RND_PC) >>> cvea_pkg::EX_SHIFT);
    term4_d.energy = TERM_W'(en3_q);
    term4_d.et     = et3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q    <= cmd_i;
    region1_q <= region_i;
    en1_q     <= energy_i;

    cmd2_q    <= cmd1_q;
    region2_q <= region1_q;
    en2_q     <= en1_q;
    p2_q      <= p2_d;
    sin2_q    <= sin2_d;
    cos2_q    <= cos2_d;

    cmd3_q    <= cmd2_q;
    region3_q <= region2_q;
    en3_q     <= en2_q;
    pc3_q     <= pc3_d;
    ps3_q     <= ps3_d;
    et3_q     <= et3_d;

    term4_q   <= term4_d;
  end

  assign term_valid_o = v4_q;
  assign term_o       = term4_q;

endmodule

FILE: hdl/cvea_acc_mem.sv
// ----------------------------------------------------------------------------
// cvea_acc_mem
// Per-region accumulator memory with registered read, saturating
// read-modify-write and one-deep write-back forwarding.
// ----------------------------------------------------------------------------
module cvea_acc_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               term_valid_i,
  input  cvea_pkg::term_t    term_i,
  input  cvea_pkg::drain_t   drain_i,
  output logic               close_o,
  output cvea_pkg::acc_rec_t rd_rec_o
);

  localparam int ACC_BITS    = cvea_pkg::ACC_BITS;
  localparam int TERM_W      = cvea_pkg::TERM_W;
  localparam int REGION_W    = cvea_pkg::REGION_W;
  localparam int NUM_REGIONS = cvea_pkg::NUM_REGIONS;

  typedef struct packed {
    logic                       sat;
    logic signed [ACC_BITS-1:0] value;
  } sat_sum_t;

  function automatic sat_sum_t sat_add(input logic signed [ACC_BITS-1:0] acc,
                                       input logic signed [TERM_W-1:0]   term);
    logic signed [ACC_BITS:0] sum;
    sat_sum_t                 res;
    sum     = (ACC_BITS+1)'(acc) + (ACC_BITS+1)'(term);
    res.sat = sum[ACC_BITS] ^ sum[ACC_BITS-1];
    // clamp towards the sign of the true sum
    res.value = res.sat ? {sum[ACC_BITS], {(ACC_BITS-1){~sum[ACC_BITS]}}}
                        : sum[ACC_BITS-1:0];
    return res;
  endfunction

  cvea_pkg::acc_rec_t mem_q [NUM_REGIONS];
  cvea_pkg::acc_rec_t rd_q;
  logic [REGION_W-1:0] rd_addr_q;
  logic [REGION_W-1:0] rd_addr;
  logic                rd_en;

  logic                s5_valid_q;
  cvea_pkg::term_t     s5_q;
  logic                hit5;

  logic [NUM_REGIONS-1:0] valid_d, valid_q;

  logic                wb_valid_q;
  logic [REGION_W-1:0] wb_region_q;
  cvea_pkg::acc_rec_t  wb_rec_q;

  cvea_pkg::acc_rec_t  stored;
  cvea_pkg::acc_rec_t  base;
  cvea_pkg::acc_rec_t  upd;
  sat_sum_t            s_ex, s_ey, s_en, s_et;

  always_comb begin
    rd_en   = (term_valid_i && term_i.cmd == cvea_pkg::CMD_ADD) || drain_i.rd_en;
    rd_addr = drain_i.rd_en ? drain_i.idx : term_i.region;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q      <= mem_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (hit5) mem_q[s5_q.region] <= upd;
  end

  always_comb begin
    hit5    = s5_valid_q && s5_q.cmd == cvea_pkg::CMD_ADD;
    close_o = s5_valid_q && s5_q.cmd == cvea_pkg::CMD_CLOSE;

    // an entry not written since it was last cleared reads as zero
    stored = valid_q[rd_addr_q] ? rd_q : '0;
    // the previous item's write lands at the edge this read was taken
    base   = (wb_valid_q && wb_region_q == s5_q.region) ? wb_rec_q : stored;

    s_ex = sat_add(base.ex,     s5_q.ex);
    s_ey = sat_add(base.ey,     s5_q.ey);
    s_en = sat_add(base.energy, s5_q.energy);
    s_et = sat_add(base.trans,  s5_q.et);

    upd.ex     = s_ex.value;
    upd.ey     = s_ey.value;
    upd.energy = s_en.value;
    upd.trans  = s_et.value;
    upd.sat    = base.sat | s_ex.sat | s_ey.sat | s_en.sat | s_et.sat;

    valid_d = valid_q;
    if (hit5) valid_d[s5_q.region] = 1'b1;
    if (drain_i.clr) valid_d[drain_i.idx] = 1'b0;

    rd_rec_o = stored;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      valid_q    <= '0;
      wb_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= term_valid_i;
      valid_q    <= valid_d;
      wb_valid_q <= hit5;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_q        <= term_i;
    wb_region_q <= s5_q.region;
    wb_rec_q    <= upd;
  end

endmodule

FILE: hdl/calo_vector_et_accumulator.sv
// ----------------------------------------------------------------------------
// calo_vector_et_accumulator
// Per-region missing-Et vector sums of calorimeter hits; a close command
// reads out the four regions in order and clears them.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                            | tuser     | tlast
//  s_axis  | in  | region, eta, phi_angle, energy (48 bits)      | cmd       | -
//  m_axis  | out | out_region, sum_ex, sum_ey, sum_energy,       | saturated | last
//          |     | sum_trans (168 bits)                          |           |
//
//  Hits are taken one per cycle unless a close has stopped intake; each reaches
//  the accumulator memory via table read, two multiply stages, rounding, RMW.
//  A close stops intake until all four results are loaded into the output
//  register, each region by a read state and a load state held by output stalls.
//  Reset clears only control state; accumulators read as zero until written.
//  A stalled output holds its item and delays only the close read-out.
// ----------------------------------------------------------------------------
module calo_vector_et_accumulator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // region[1:0], eta[13:2], phi_angle[25:14], energy[42:26]
  input  logic [cvea_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // cmd[0]
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_region[1:0], sum_ex[41:2], sum_ey[81:42], sum_energy[121:82],
  // sum_trans[161:122]
  output logic [cvea_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // saturated[0]
  output logic [0:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int REGION_W = cvea_pkg::REGION_W;
  localparam int ETA_W    = cvea_pkg::ETA_W;
  localparam int PHI_W    = cvea_pkg::PHI_W;
  localparam int ENERGY_W = cvea_pkg::ENERGY_W;
  localparam int SUM_W    = cvea_pkg::SUM_W;
  localparam int ETA_LSB  = REGION_W;
  localparam int PHI_LSB  = ETA_LSB + ETA_W;
  localparam int EN_LSB   = PHI_LSB + PHI_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LD   = 2'd2;

  logic                       s_accept;
  logic [REGION_W-1:0]        in_region;
  logic signed [ETA_W-1:0]    in_eta;
  logic [PHI_W-1:0]           in_phi;
  logic signed [ENERGY_W-1:0] in_energy;

  cvea_pkg::trig_t    trig;
  logic               term_valid;
  cvea_pkg::term_t    term;
  cvea_pkg::drain_t   drain;
  logic               close_seen;
  cvea_pkg::acc_rec_t rd_rec;

  logic [1:0]          state_d, state_q;
  logic [REGION_W-1:0] cnt_d, cnt_q;
  logic                busy_d, busy_q;
  logic                out_load;

  logic                out_valid_d, out_valid_q;
  cvea_pkg::acc_rec_t  out_rec_q;
  logic [REGION_W-1:0] out_region_q;
  logic                out_last_q;

  assign s_axis_tready = ~busy_q;
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign in_region     = s_axis_tdata[ETA_LSB-1:0];
  assign in_eta        = $signed(s_axis_tdata[PHI_LSB-1:ETA_LSB]);
  assign in_phi        = s_axis_tdata[EN_LSB-1:PHI_LSB];
  assign in_energy     = $signed(s_axis_tdata[EN_LSB+ENERGY_W-1:EN_LSB]);

  cvea_trig_rom u_trig_rom (
    .clk_i   (clk_i),
    .rd_en_i (s_accept),
    .eta_i   (in_eta),
    .phi_i   (in_phi),
    .trig_o  (trig)
  );

  cvea_et_pipe u_et_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (s_accept),
    .cmd_i        (s_axis_tuser[0]),
    .region_i     (in_region),
    .energy_i     (in_energy),
    .trig_i       (trig),
    .term_valid_o (term_valid),
    .term_o       (term)
  );

  cvea_acc_mem u_acc_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_valid_i (term_valid),
    .term_i       (term),
    .drain_i      (drain),
    .close_o      (close_seen),
    .rd_rec_o     (rd_rec)
  );

  // close read-out: the close reaches the RMW stage after every earlier hit
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    drain     = '0;
    drain.idx = cnt_q;
    out_load  = 1'b0;
    if (s_accept && s_axis_tuser[0] == cvea_pkg::CMD_CLOSE) busy_d = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (close_seen) begin
          state_d = ST_RD;
          cnt_d   = '0;
        end
      end
      ST_RD: begin
        drain.rd_en = 1'b1;
        state_d     = ST_LD;
      end
      ST_LD: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load  = 1'b1;
          drain.clr = 1'b1;
          cnt_d     = cnt_q + REGION_W'(1);
          if (cnt_q == REGION_W'(cvea_pkg::NUM_REGIONS - 1)) begin
            state_d = ST_IDLE;
            busy_d  = 1'b0;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rec_q    <= rd_rec;
      out_region_q <= cnt_q;
      out_last_q   <= (cnt_q == REGION_W'(cvea_pkg::NUM_REGIONS - 1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = cvea_pkg::M_TDATA_W'({SUM_W'(out_rec_q.trans),
                                                SUM_W'(out_rec_q.energy),
                                                SUM_W'(out_rec_q.ey),
                                                SUM_W'(out_rec_q.ex),
                                                out_region_q});
  assign m_axis_tuser  = out_rec_q.sat;
  assign m_axis_tlast  = out_last_q;

endmodule
